// File: hw/rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared constants for the coordinate packet deframer: header and flag codes,
// frame positions and field widths.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned USER_W  = 3;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] FLAG_LINE = 8'h01;
    localparam logic [BYTE_W-1:0] FLAG_STEP = 8'h02;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd656;

    // Frame positions: 0 and 1 are the header, 2 is the motion flag,
    // 3 to 6 carry x, 7 to 10 carry y and 11 is the checksum.
    localparam logic [POS_W-1:0] POS_FLAG   = 4'd2;
    localparam logic [POS_W-1:0] POS_X_LAST = 4'd6;
    localparam logic [POS_W-1:0] POS_LAST   = 4'd11;

endpackage

// File: hw/rtl/coord_packet_deframer.sv
// ----------------------------------------------------------------------------
// coord_packet_deframer
// Hunts for a 0xFF 0xFF header in a byte stream, collects a 12-byte frame,
// checks its inverted-sum checksum and emits the decoded motion record.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake         Payload
//  s_       in   s_tvalid/tready   s_tdata[7:0] = rx_byte
//  m_       out  m_tvalid/tready   m_tdata[63:0] = y_coord:x_coord,
//                                  m_tuser[2:0] = motion_kind:kind_valid:checksum_ok
//  cfg_     in   cfg_we            cfg_wdata[30:0] = coord_limit
//
// One byte is taken per cycle while no checksum byte waits. A byte is captured in an
// input register and processed from there; a finished frame moves into the result
// register when its checksum byte is processed. The result register holds
// while m_tready is low; only a checksum byte then waits, other bytes flow on.
// Reset (aresetn low, synchronous) returns the deframer to header hunting and
// coord_limit to 656.
// ----------------------------------------------------------------------------
module coord_packet_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cpd_pkg::LIMIT_W-1:0]        cfg_wdata,  // coord_limit
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cpd_pkg::BYTE_W-1:0]         s_tdata,    // rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*cpd_pkg::COORD_W-1:0]      m_tdata,    // x_coord, y_coord
    output logic [cpd_pkg::USER_W-1:0]         m_tuser     // checksum_ok, kind_valid,
                                                           // motion_kind
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [cpd_pkg::LIMIT_W-1:0]  limit_reg;
    logic                         in_valid_reg;
    logic [cpd_pkg::BYTE_W-1:0]   in_byte_reg;
    logic [1:0]                   phase_reg, phase_next;
    logic [cpd_pkg::POS_W-1:0]    index_reg, index_next;
    logic [cpd_pkg::BYTE_W-1:0]   sum_reg, sum_next;
    logic [cpd_pkg::BYTE_W-1:0]   motion_reg, motion_next;
    logic [cpd_pkg::COORD_W-1:0]  x_reg, x_next;
    logic [cpd_pkg::COORD_W-1:0]  y_reg, y_next;
    logic                         out_valid_reg;
    logic [2*cpd_pkg::COORD_W-1:0] out_data_reg;
    logic [cpd_pkg::USER_W-1:0]   out_user_reg;

    logic                         is_last;
    logic                         out_free;
    logic                         stage_fire;
    logic                         out_load;
    logic                         csum_ok;
    logic                         kind_ok;
    logic                         kind_step;
    logic [cpd_pkg::COORD_W-1:0]  x_sat;
    logic [cpd_pkg::COORD_W-1:0]  y_sat;
    logic signed [cpd_pkg::COORD_W-1:0] limit_s;

    assign is_last    = (phase_reg == PH_BODY) && (index_reg == cpd_pkg::POS_LAST);
    assign out_free   = !out_valid_reg || m_tready;
    assign stage_fire = in_valid_reg && (!is_last || out_free);
    assign out_load   = stage_fire && is_last;
    assign s_tready   = !in_valid_reg || stage_fire;

    // Result fields, formed from the state left by bytes 2 to 10 and the checksum byte.
    assign csum_ok   = (~sum_reg) == in_byte_reg;
    assign kind_ok   = (motion_reg == cpd_pkg::FLAG_LINE) ||
                       (motion_reg == cpd_pkg::FLAG_STEP);
    assign kind_step = motion_reg == cpd_pkg::FLAG_STEP;
    assign limit_s   = signed'({1'b0, limit_reg});
    assign x_sat     = (signed'(x_reg) > limit_s) ? unsigned'(limit_s) : x_reg;
    assign y_sat     = (signed'(y_reg) > limit_s) ? unsigned'(limit_s) : y_reg;

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        motion_next = motion_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        unique case (phase_reg)
            PH_HDR: begin
                if (in_byte_reg == cpd_pkg::HDR_BYTE) begin
                    phase_next = PH_BODY;
                    index_next = cpd_pkg::POS_FLAG;
                    sum_next   = '0;
                    x_next     = '0;
                    y_next     = '0;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_BODY: begin
                if (is_last) begin
                    phase_next = PH_HUNT;
                    index_next = '0;
                end else begin
                    sum_next   = sum_reg + in_byte_reg;
                    index_next = index_reg + cpd_pkg::POS_W'(1);
                    if (index_reg == cpd_pkg::POS_FLAG) begin
                        motion_next = in_byte_reg;
                    end else if (index_reg <= cpd_pkg::POS_X_LAST) begin
                        x_next = {x_reg[cpd_pkg::COORD_W-cpd_pkg::BYTE_W-1:0], in_byte_reg};
                    end else begin
                        y_next = {y_reg[cpd_pkg::COORD_W-cpd_pkg::BYTE_W-1:0], in_byte_reg};
                    end
                end
            end
            default: begin
                phase_next = (in_byte_reg == cpd_pkg::HDR_BYTE) ? PH_HDR : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= cpd_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            index_reg  <= '0;
            sum_reg    <= '0;
            motion_reg <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
        end else if (stage_fire) begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            sum_reg    <= sum_next;
            motion_reg <= motion_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {y_sat, x_sat};
            out_user_reg <= {kind_step, kind_ok, csum_ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_body_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> index_reg >= cpd_pkg::POS_FLAG &&
                                 index_reg <= cpd_pkg::POS_LAST)
        else $error("body position out of frame range");

    a_last_byte_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && phase_reg == PH_HUNT)
        else $error("checksum byte did not produce a result");

    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !stage_fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte was lost or changed");

    a_header_starts_body: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && phase_reg == PH_HDR && in_byte_reg == cpd_pkg::HDR_BYTE
        |=> phase_reg == PH_BODY && index_reg == cpd_pkg::POS_FLAG && sum_reg == '0)
        else $error("second header byte did not open a clean frame");

    a_no_result_midframe: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(out_load) && $past(out_free) |-> !m_tvalid)
        else $error("result appeared without a checksum byte");
`endif

endmodule

// File: tb/coord_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// coord_packet_deframer_test
// Self-checking testbench for the coordinate packet deframer. A queue of
// serial bytes (whole frames, broken headers, misaligned runs and line noise)
// is streamed into the block, mostly with random gaps. Every accepted byte also runs
// through a local deframer model. Each motion record that leaves the block is
// compared field by field with the oldest expected one. The saturation limit
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module coord_packet_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        HUNT,
        HDR_SEEN,
        BODY,
        PHASE_SPARE
    } sync_t;

    typedef struct packed {
        logic              cks_ok;
        logic              kind_ok;
        logic              kind_step;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } motion_rec_t;

    typedef struct {
        logic [cpd_pkg::BYTE_W-1:0] data;
        int unsigned                gap;
        bit                         hold_after;
    } serial_byte_t;

    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned SETTLE_CYCS  = 6;

    // Idle styles shared by both sides.
    localparam int unsigned IDLE_NONE   = 0;
    localparam int unsigned IDLE_RANDOM = 1;
    localparam int unsigned IDLE_SPARSE = 2;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [cpd_pkg::LIMIT_W-1:0]      cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [cpd_pkg::BYTE_W-1:0]       s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [2*cpd_pkg::COORD_W-1:0]    m_tdata;
    logic [cpd_pkg::USER_W-1:0]       m_tuser;

    coord_packet_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stimulus and scoreboard storage.
    serial_byte_t serial_q[$];
    motion_rec_t  motion_q[$];

    int unsigned tx_mode = IDLE_RANDOM;
    int unsigned rx_mode = IDLE_RANDOM;

    int unsigned bytes_queued    = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned records_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned limits_used     = 1;

    // Local copy of the deframer state and its register.
    logic [cpd_pkg::LIMIT_W-1:0] limit_model = cpd_pkg::LIMIT_RESET;
    sync_t                       sync_st     = HUNT;
    logic [cpd_pkg::POS_W-1:0]   body_pos    = '0;
    logic [cpd_pkg::BYTE_W-1:0]  csum_acc    = '0;
    logic [cpd_pkg::BYTE_W-1:0]  flag_byte   = '0;
    logic [cpd_pkg::COORD_W-1:0] x_acc       = '0;
    logic [cpd_pkg::COORD_W-1:0] y_acc       = '0;

    function automatic int unsigned draw_gap(input int unsigned mode);
        if (mode == IDLE_NONE) begin
            return 0;
        end
        if (mode == IDLE_SPARSE) begin
            return (($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0);
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [cpd_pkg::COORD_W-1:0] clip_coord(
        input logic [cpd_pkg::COORD_W-1:0] v
    );
        if ($signed(v) > $signed({1'b0, limit_model})) begin
            return {1'b0, limit_model};
        end
        return v;
    endfunction

    // Advances the local deframer by one byte; a checksum byte queues a record.
    function automatic void deframe_byte(input logic [cpd_pkg::BYTE_W-1:0] b);
        motion_rec_t rec;
        case (sync_st)
            HDR_SEEN: begin
                if (b == cpd_pkg::HDR_BYTE) begin
                    sync_st  = BODY;
                    body_pos = cpd_pkg::POS_FLAG;
                    csum_acc = '0;
                    x_acc    = '0;
                    y_acc    = '0;
                end else begin
                    sync_st = HUNT;
                end
            end
            BODY: begin
                if (body_pos != cpd_pkg::POS_LAST) begin
                    csum_acc = csum_acc + b;
                    if (body_pos == cpd_pkg::POS_FLAG) begin
                        flag_byte = b;
                    end else if (body_pos <= cpd_pkg::POS_X_LAST) begin
                        x_acc = {x_acc[23:0], b};
                    end else begin
                        y_acc = {y_acc[23:0], b};
                    end
                    body_pos = body_pos + cpd_pkg::POS_W'(1);
                end else begin
                    rec.cks_ok    = (cpd_pkg::BYTE_W'(~csum_acc) == b);
                    rec.kind_ok   = (flag_byte == cpd_pkg::FLAG_LINE) ||
                                    (flag_byte == cpd_pkg::FLAG_STEP);
                    rec.kind_step = (flag_byte == cpd_pkg::FLAG_STEP);
                    rec.x         = clip_coord(x_acc);
                    rec.y         = clip_coord(y_acc);
                    motion_q.push_back(rec);
                    sync_st  = HUNT;
                    body_pos = '0;
                end
            end
            default: begin
                sync_st = (b == cpd_pkg::HDR_BYTE) ? HDR_SEEN : HUNT;
            end
        endcase
    endfunction

    // Sender: presents queued bytes, idling after each for its drawn gap or a pause.
    int unsigned tx_gap_left = 0;
    bit          tx_pause    = 1'b0;

    always @(posedge aclk) begin
        serial_byte_t nxt;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            tx_gap_left <= 0;
            tx_pause    <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (tx_gap_left != 0) begin
                s_tvalid    <= 1'b0;
                tx_gap_left <= tx_gap_left - 1;
            end else if (tx_pause) begin
                // Hold off until every outstanding record has come back.
                s_tvalid <= 1'b0;
                if (motion_q.size() == 0) begin
                    tx_pause <= 1'b0;
                end
            end else if (serial_q.size() != 0) begin
                nxt = serial_q.pop_front();
                s_tvalid    <= 1'b1;
                s_tdata     <= nxt.data;
                tx_gap_left <= nxt.gap;
                tx_pause    <= nxt.hold_after;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a one-cycle request.
    logic        rx_hold_go   = 1'b0;
    int unsigned rx_hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left <= 0;
        end else if (rx_hold_go) begin
            rx_hold_left <= LONG_HOLD;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Receiver: stalls for a drawn gap after each record and during a long hold-off.
    int unsigned rx_stall_left = 0;

    always @(posedge aclk) begin
        int unsigned stall_nxt;
        if (!aresetn) begin
            m_tready      <= 1'b0;
            rx_stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                stall_nxt = draw_gap(rx_mode);
            end else begin
                stall_nxt = (rx_stall_left != 0) ? rx_stall_left - 1 : 0;
            end
            rx_stall_left <= stall_nxt;
            m_tready      <= (stall_nxt == 0) && (rx_hold_left == 0);
        end
    end

    // Monitor: predicts on every input transaction, checks every output one.
    always @(posedge aclk) begin
        motion_rec_t want;
        motion_rec_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bytes_accepted++;
                deframe_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got.cks_ok    = m_tuser[0];
                got.kind_ok   = m_tuser[1];
                got.kind_step = m_tuser[2];
                got.x         = m_tdata[cpd_pkg::COORD_W-1:0];
                got.y         = m_tdata[2*cpd_pkg::COORD_W-1:cpd_pkg::COORD_W];
                if (motion_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected record: cks=%0b ok=%0b step=%0b x=%0d y=%0d",
                                 $realtime, got.cks_ok, got.kind_ok, got.kind_step,
                                 got.x, got.y);
                    end
                end else begin
                    want = motion_q.pop_front();
                    records_checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] mismatch exp cks=%0b ok=%0b step=%0b x=%0d y=%0d",
                                     $realtime, want.cks_ok, want.kind_ok, want.kind_step,
                                     want.x, want.y);
                            $display("              got cks=%0b ok=%0b step=%0b x=%0d y=%0d",
                                     got.cks_ok, got.kind_ok, got.kind_step, got.x, got.y);
                        end
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [cpd_pkg::BYTE_W-1:0] b, input bit hold_after);
        serial_byte_t item;
        item.data       = b;
        item.gap        = draw_gap(tx_mode);
        item.hold_after = hold_after;
        // The pause check must start only after the record is in the queue.
        if (hold_after && item.gap == 0) begin
            item.gap = 1;
        end
        serial_q.push_back(item);
        bytes_queued++;
    endtask

    task automatic push_frame(input logic [cpd_pkg::BYTE_W-1:0] flag,
                              input logic [cpd_pkg::COORD_W-1:0] x,
                              input logic [cpd_pkg::COORD_W-1:0] y, input bit corrupt,
                              input bit hold_after);
        logic [cpd_pkg::BYTE_W-1:0] fb [12];
        logic [cpd_pkg::BYTE_W-1:0] sum;
        fb[0] = cpd_pkg::HDR_BYTE;
        fb[1] = cpd_pkg::HDR_BYTE;
        fb[2] = flag;
        for (int k = 0; k < 4; k++) begin
            fb[3 + k] = x[31 - 8*k -: 8];
            fb[7 + k] = y[31 - 8*k -: 8];
        end
        sum = '0;
        for (int k = 2; k <= 10; k++) begin
            sum = sum + fb[k];
        end
        fb[11] = ~sum;
        if (corrupt) begin
            fb[11] = fb[11] ^ cpd_pkg::BYTE_W'($urandom_range(1, 255));
        end
        for (int k = 0; k < 12; k++) begin
            push_byte(fb[k], hold_after && (k == 11));
        end
    endtask

    function automatic logic [cpd_pkg::COORD_W-1:0] pick_coord();
        logic [cpd_pkg::COORD_W-1:0] lim;
        lim = {1'b0, limit_model};
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return lim;
            2: return lim + 1;
            3: return lim - 1;
            4: return 32'h7FFF_FFFF;
            5: return 32'h8000_0000;
            6: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom() % (lim + 1);
        endcase
    endfunction

    function automatic logic [cpd_pkg::BYTE_W-1:0] pick_flag();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return cpd_pkg::FLAG_LINE;
            4, 5, 6, 7: return cpd_pkg::FLAG_STEP;
            8:          return cpd_pkg::HDR_BYTE;
            default:    return cpd_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames with random content, plus noise and broken headers.
    task automatic queue_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                push_frame(pick_flag(), pick_coord(), pick_coord(),
                           $urandom_range(0, 9) == 0, $urandom_range(0, 39) == 0);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) begin
                    push_byte(cpd_pkg::BYTE_W'($urandom_range(0, 254)), 1'b0);
                end
            end else if (pick < 88) begin
                push_byte(cpd_pkg::HDR_BYTE, 1'b0);
                push_byte(cpd_pkg::BYTE_W'($urandom_range(0, 254)), 1'b0);
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 4)) begin
                    push_byte(cpd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
                end
            end else begin
                // A stray header byte misaligns the frame that follows.
                push_byte(cpd_pkg::HDR_BYTE, 1'b0);
                push_frame(pick_flag(), pick_coord(), pick_coord(), 1'b0, 1'b0);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (serial_q.size() != 0 || s_tvalid || tx_pause || motion_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCS) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [cpd_pkg::LIMIT_W-1:0] lim);
        @(posedge aclk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= lim;
        limit_model  = lim;
        @(posedge aclk);
        cfg_we <= 1'b0;
        limits_used++;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: broken header, flag 0xFF right after the header,
        // coordinate extremes, both motion kinds and a bad checksum.
        tx_mode = IDLE_RANDOM;
        rx_mode = IDLE_RANDOM;
        push_byte(cpd_pkg::HDR_BYTE, 1'b0);
        push_byte(8'h00, 1'b0);
        push_frame(cpd_pkg::HDR_BYTE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        push_frame(cpd_pkg::FLAG_LINE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_frame(cpd_pkg::FLAG_STEP, 32'd656, 32'd657, 1'b1, 1'b1);
        queue_traffic(360);
        wait_idle();

        // Zero limit, no idling, and a long receiver hold that backs up the input.
        write_limit('0);
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        queue_traffic(360);
        @(posedge aclk);
        rx_hold_go <= 1'b1;
        @(posedge aclk);
        rx_hold_go <= 1'b0;
        wait_idle();

        write_limit({cpd_pkg::LIMIT_W{1'b1}});
        tx_mode = IDLE_SPARSE;
        rx_mode = IDLE_RANDOM;
        queue_traffic(360);
        wait_idle();

        write_limit(cpd_pkg::LIMIT_W'($urandom()));
        tx_mode = IDLE_RANDOM;
        rx_mode = IDLE_SPARSE;
        queue_traffic(360);
        wait_idle();

        write_limit(cpd_pkg::LIMIT_W'(1));
        tx_mode = IDLE_RANDOM;
        rx_mode = IDLE_RANDOM;
        queue_traffic(360);
        wait_idle();

        repeat (10) @(posedge aclk);
        $display("Streamed %0d bytes and checked %0d motion records under %0d limit settings,",
                 bytes_accepted, records_checked, limits_used);
        $display("including a zero limit, the full 31-bit limit, back-pressure and broken headers.");
        if (mismatches == 0 && motion_q.size() == 0) begin
            $display("coord_packet_deframer verification clean");
        end else begin
            $display("%0d mismatching records, %0d expected records never arrived",
                     mismatches, motion_q.size());
            $display("coord_packet_deframer verification failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Run timed out with %0d bytes and %0d records outstanding",
                 serial_q.size(), motion_q.size());
        $display("coord_packet_deframer verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cpd_pkg.sv
hw/rtl/coord_packet_deframer.sv
tb/coord_packet_deframer_test.sv
